// ===== rtl/irs_pkg.sv =====
package irs_pkg;

   localparam int MAX_SIDE_DEF    = 32;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int POS_W      = 8;
   localparam int VALUE_W    = 16;
   localparam int SIDE_W     = 6;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // leaves per group of the availability search tree
   localparam int GROUP_W = 16;

   localparam logic [SIDE_W-1:0]  BLOCK_SIDE_RESET    = 6'd4;
   localparam logic [VALUE_W-1:0] DEFAULT_VALUE_RESET = 16'd128;

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_READ = 1'b1
   } req_kind_type;

   typedef enum logic {
      REG_BLOCK_SIDE    = 1'b0,
      REG_DEFAULT_VALUE = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic load;
      logic start;
   } search_ctrl_type;

endpackage

// ===== rtl/irs_sample_mem.sv =====
module irs_sample_mem #(
   parameter int DEPTH  = 129,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/irs_mask_search.sv =====
module irs_mask_search #(
   parameter int DEPTH = 129,
   parameter int IDX_W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  irs_pkg::search_ctrl_type      ctrl,
   input  logic [irs_pkg::POS_W-1:0]     pos,
   input  logic                          load_avail,
   input  logic [IDX_W-1:0]              last,
   output logic                          own_avail,
   output logic                          found,
   output logic [IDX_W-1:0]              hit_index
);

   localparam int GW    = irs_pkg::GROUP_W;
   localparam int GB    = $clog2(GW);
   localparam int NG    = (DEPTH + GW - 1) / GW;
   localparam int NGB   = (NG > 1) ? $clog2(NG) : 1;
   localparam int PAD   = NG * GW;
   localparam int CMP_W = ((irs_pkg::POS_W > IDX_W) ? irs_pkg::POS_W : IDX_W) + 1;

   logic [DEPTH-1:0] avail_ff, avail_in;
   logic [PAD-1:0]   avail_pad;
   logic [CMP_W-1:0] pos_wide, last_wide;
   logic             pos_in_store;

   logic [PAD-1:0]   below_vec, all_vec;
   logic [NG-1:0]    below_any_in, all_any_in;
   logic [GB-1:0]    below_hi_in [NG];
   logic [GB-1:0]    all_lo_in [NG];

   logic [NG-1:0]    below_any_ff, all_any_ff;
   logic [GB-1:0]    below_hi_ff [NG];
   logic [GB-1:0]    all_lo_ff [NG];
   logic             own_ff;

   assign pos_wide     = CMP_W'(pos);
   assign last_wide    = CMP_W'(last);
   assign pos_in_store = pos_wide < CMP_W'(DEPTH);
   assign avail_pad    = PAD'(avail_ff);

   always_comb begin
      avail_in = avail_ff;
      if (ctrl.load && pos_in_store) begin
         avail_in[pos_wide[IDX_W-1:0]] = load_avail;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff <= '0;
      end else begin
         avail_ff <= avail_in;
      end
   end

   // leaf level: qualify each entry, then per group the highest hit below and lowest in line
   always_comb begin
      logic [GW-1:0] grp, rev, oh_lo, oh_hi;
      for (int q = 0; q < PAD; q++) begin
         below_vec[q] = avail_pad[q] && (CMP_W'(q) < pos_wide);
         all_vec[q]   = avail_pad[q] && (CMP_W'(q) <= last_wide);
      end
      for (int g = 0; g < NG; g++) begin
         grp   = below_vec[g*GW +: GW];
         for (int i = 0; i < GW; i++) begin
            rev[i] = grp[GW-1-i];
         end
         oh_lo = rev & (~rev + GW'(1));
         for (int i = 0; i < GW; i++) begin
            oh_hi[i] = oh_lo[GW-1-i];
         end
         below_any_in[g] = |grp;
         below_hi_in[g]  = '0;
         for (int i = 0; i < GW; i++) begin
            if (oh_hi[i]) begin
               below_hi_in[g] = below_hi_in[g] | GB'(i);
            end
         end

         grp   = all_vec[g*GW +: GW];
         oh_lo = grp & (~grp + GW'(1));
         all_any_in[g] = |grp;
         all_lo_in[g]  = '0;
         for (int i = 0; i < GW; i++) begin
            if (oh_lo[i]) begin
               all_lo_in[g] = all_lo_in[g] | GB'(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         below_any_ff <= below_any_in;
         all_any_ff   <= all_any_in;
         below_hi_ff  <= below_hi_in;
         all_lo_ff    <= all_lo_in;
         own_ff       <= pos_in_store && avail_pad[pos_wide[IDX_W-1:0]];
      end
   end

   // group level: nearest group below wins, else first group in the line
   always_comb begin
      logic [NG-1:0]        rev_g, oh_rev, oh_below, oh_all;
      logic [NGB+GB-1:0]    idx_below, idx_all;
      for (int g = 0; g < NG; g++) begin
         rev_g[g] = below_any_ff[NG-1-g];
      end
      oh_rev = rev_g & (~rev_g + NG'(1));
      for (int g = 0; g < NG; g++) begin
         oh_below[g] = oh_rev[NG-1-g];
      end
      oh_all = all_any_ff & (~all_any_ff + NG'(1));
      idx_below = '0;
      idx_all   = '0;
      for (int g = 0; g < NG; g++) begin
         if (oh_below[g]) begin
            idx_below = idx_below | {NGB'(g), below_hi_ff[g]};
         end
         if (oh_all[g]) begin
            idx_all = idx_all | {NGB'(g), all_lo_ff[g]};
         end
      end
      found     = (|below_any_ff) || (|all_any_ff);
      hit_index = (|below_any_ff) ? IDX_W'(idx_below) : IDX_W'(idx_all);
   end

   assign own_avail = own_ff;

endmodule

// ===== rtl/intra_reference_substitution.sv =====
// channel   direction  words                                         handshake
// req_*     in         req_type, position, sample_in, available_in   req_valid / req_stall
// rsp_*     out        position_out, value_out, was_substituted,     rsp_valid / rsp_stall
//                      used_default
// csr_*     in/out     block_side (0x0), default_value (0x4)         apb, pready tied high
//
// a load word: sample memory and availability flop written at acceptance
// a read word: group search registered, then memory read, then output register
// req_stall is high while a read is in flight; loads pass while a result waits on rsp_stall
// synchronous reset clears availability (all unavailable), block_side to 4 and
// default_value to 128; the sample memory is not cleared and needs no clearing pass
module intra_reference_substitution #(
   parameter int MAX_SIDE    = irs_pkg::MAX_SIDE_DEF,
   parameter int SAMPLE_BITS = irs_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_type,
   input  logic [irs_pkg::POS_W-1:0]       req_position,
   input  logic [irs_pkg::VALUE_W-1:0]     req_sample_in,
   input  logic                            req_available_in,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [irs_pkg::POS_W-1:0]       rsp_position_out,
   output logic [irs_pkg::VALUE_W-1:0]     rsp_value_out,
   output logic                            rsp_was_substituted,
   output logic                            rsp_used_default,

   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [irs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [irs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [irs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int DEPTH = 4 * MAX_SIDE + 1;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = ((irs_pkg::POS_W > IDX_W) ? irs_pkg::POS_W : IDX_W) + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PICK,
      ST_FETCH
   } state_type;

   state_type                        state_ff;
   logic [irs_pkg::SIDE_W-1:0]       block_side_ff;
   logic [irs_pkg::VALUE_W-1:0]      default_ff;

   logic [irs_pkg::POS_W-1:0]        pos_ff;
   logic                             in_line_ff;
   logic                             subst_ff, dflt_ff;

   logic                             rsp_valid_ff;
   logic [irs_pkg::POS_W-1:0]        rsp_pos_ff;
   logic [irs_pkg::VALUE_W-1:0]      rsp_value_ff;
   logic                             rsp_subst_ff, rsp_dflt_ff;

   logic                             accept, accept_load, accept_read;
   logic                             cfg_write, out_free;
   logic [CMP_W-1:0]                 line4_wide, last_wide, req_pos_wide, pos_ff_wide;
   logic [IDX_W-1:0]                 last;
   irs_pkg::search_ctrl_type         search_ctrl;
   logic                             own_avail, found;
   logic [IDX_W-1:0]                 hit_index, rd_addr;
   logic                             subst_in, dflt_in;
   logic [SAMPLE_BITS-1:0]           rd_data;
   logic [irs_pkg::VALUE_W-1:0]      value_in;

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign accept_load = accept &&
                        (irs_pkg::req_kind_type'(req_type) == irs_pkg::REQ_LOAD);
   assign accept_read = accept &&
                        (irs_pkg::req_kind_type'(req_type) == irs_pkg::REQ_READ);
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // line end is 4N, held to the last entry of the store
   assign line4_wide   = CMP_W'({block_side_ff, 2'b00});
   assign last_wide    = (line4_wide > CMP_W'(DEPTH - 1)) ? CMP_W'(DEPTH - 1) : line4_wide;
   assign last         = last_wide[IDX_W-1:0];
   assign req_pos_wide = CMP_W'(req_position);
   assign pos_ff_wide  = CMP_W'(pos_ff);

   // config port
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      case (irs_pkg::reg_index_type'(csr_paddr[2]))
         irs_pkg::REG_BLOCK_SIDE:    csr_prdata = irs_pkg::CSR_DATA_W'(block_side_ff);
         irs_pkg::REG_DEFAULT_VALUE: csr_prdata = irs_pkg::CSR_DATA_W'(default_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_side_ff <= irs_pkg::BLOCK_SIDE_RESET;
         default_ff    <= irs_pkg::DEFAULT_VALUE_RESET;
      end else if (cfg_write) begin
         case (irs_pkg::reg_index_type'(csr_paddr[2]))
            irs_pkg::REG_BLOCK_SIDE:    block_side_ff <= csr_pwdata[irs_pkg::SIDE_W-1:0];
            irs_pkg::REG_DEFAULT_VALUE: default_ff    <= csr_pwdata[irs_pkg::VALUE_W-1:0];
            default: ;
         endcase
      end
   end

   assign search_ctrl.load  = accept_load;
   assign search_ctrl.start = accept_read;

   irs_mask_search #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_search (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (search_ctrl),
      .pos        (req_position),
      .load_avail (req_available_in),
      .last       (last),
      .own_avail  (own_avail),
      .found      (found),
      .hit_index  (hit_index)
   );

   // own sample first, then the nearest available one
   assign rd_addr  = own_avail ? pos_ff_wide[IDX_W-1:0] : hit_index;
   assign subst_in = !in_line_ff || !own_avail;
   assign dflt_in  = !in_line_ff || (!own_avail && !found);

   irs_sample_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (IDX_W),
      .DATA_W (SAMPLE_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (accept_load && (req_pos_wide < CMP_W'(DEPTH))),
      .wr_addr (req_pos_wide[IDX_W-1:0]),
      .wr_data (req_sample_in[SAMPLE_BITS-1:0]),
      .rd_en   (state_ff == ST_PICK),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign value_in = dflt_ff ? irs_pkg::VALUE_W'(default_ff[SAMPLE_BITS-1:0])
                             : irs_pkg::VALUE_W'(rd_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new word from the fetch stage takes the place of the one leaving
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FETCH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept_read) begin
                  pos_ff     <= req_position;
                  in_line_ff <= req_pos_wide <= last_wide;
                  state_ff   <= ST_PICK;
               end
            end
            ST_PICK: begin
               subst_ff <= subst_in;
               dflt_ff  <= dflt_in;
               state_ff <= ST_FETCH;
            end
            ST_FETCH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pos_ff   <= pos_ff;
                  rsp_value_ff <= value_in;
                  rsp_subst_ff <= subst_ff;
                  rsp_dflt_ff  <= dflt_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_position_out    = rsp_pos_ff;
   assign rsp_value_out       = rsp_value_ff;
   assign rsp_was_substituted = rsp_subst_ff;
   assign rsp_used_default    = rsp_dflt_ff;

   a_read_enters_pick: assert property (@(posedge clock) disable iff (reset)
      accept_read |=> state_ff == ST_PICK)
      else $error("accepted read did not start the search");

   a_pick_to_fetch: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PICK |=> state_ff == ST_FETCH)
      else $error("search stage did not hand over to the memory read");

   a_word_from_fetch: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FETCH))
      else $error("result word appeared without a memory read");

   a_default_is_substituted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_dflt_ff || rsp_subst_ff))
      else $error("default value given for a position that was available");

endmodule
